// ===== hw/rtl/iufc_pkg.sv =====
// Shared frame record type, constants and helper function of the IPv4/UDP frame checker.
package iufc_pkg;

    localparam int unsigned COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [COUNT_W-1:0] ETH_HDR = 17'd14;
    localparam logic [COUNT_W-1:0] ETHERTYPE_HI_POS = 17'd12;
    localparam logic [COUNT_W-1:0] ETHERTYPE_LO_POS = 17'd13;

    localparam logic [15:0] ETHERTYPE_MIN = 16'h0600;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0] IP_VERSION_4 = 4'd4;
    localparam logic [5:0] IP_MIN_HDR = 6'd20;
    localparam logic [5:0] UDP_HDR = 6'd8;
    localparam logic [15:0] PROTO_UDP = 16'd17;
    localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] IP_OK = 4'd0;
    localparam logic [3:0] IP_ETH_RUNT = 4'd1;
    localparam logic [3:0] IP_NOT_ETH2 = 4'd2;
    localparam logic [3:0] IP_NOT_IPV4 = 4'd3;
    localparam logic [3:0] IP_RUNT = 4'd4;
    localparam logic [3:0] IP_BAD_VERSION = 4'd5;
    localparam logic [3:0] IP_BAD_IHL = 4'd6;
    localparam logic [3:0] IP_HDR_TRUNC = 4'd7;
    localparam logic [3:0] IP_HDR_CHECKSUM = 4'd8;
    localparam logic [3:0] IP_PKT_TRUNC = 4'd9;

    localparam logic [2:0] UDP_OK = 3'd0;
    localparam logic [2:0] UDP_RUNT = 3'd1;
    localparam logic [2:0] UDP_TOO_LONG = 3'd2;
    localparam logic [2:0] UDP_BAD_CHECKSUM = 3'd3;
    localparam logic [2:0] UDP_SKIPPED = 3'd4;

    typedef struct packed {
        logic [COUNT_W-1:0] byte_pos;
        logic [15:0]        ether_type;
        logic [7:0]         version_ihl;
        logic [15:0]        total_length;
        logic [7:0]         proto_byte;
        logic [31:0]        header_sum;
        logic [15:0]        udp_length;
        logic               udp_check_nonzero;
        logic [31:0]        udp_sum;
        logic [31:0]        udp_ports;
    } t_frame_rec;

    function automatic logic [15:0] weigh(input logic odd, input logic [7:0] b);
        weigh = odd ? {8'h00, b} : {b, 8'h00};
    endfunction

endpackage

// ===== hw/rtl/iufc_in_if.sv =====
// Byte stream channel that carries frame bytes into the checker.
interface iufc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

// ===== hw/rtl/iufc_out_if.sv =====
// Result channel that carries one verdict per frame out of the checker.
interface iufc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] ip_status;
    logic [2:0] udp_status;
    logic [7:0] ip_protocol;
    logic [5:0] header_bytes;

    modport source (output valid, output ip_status, output udp_status,
                    output ip_protocol, output header_bytes, input ready);
    modport sink (input valid, input ip_status, input udp_status,
                  input ip_protocol, input header_bytes, output ready);
endinterface

// ===== hw/rtl/iufc_front.sv =====
// Byte front end: captures header fields and running sums, emits one record per frame.
module iufc_front
    import iufc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    iufc_in_if.sink      i_in,
    input  logic         i_q_full,
    output logic         o_push,
    output t_frame_rec   o_rec
);

    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [15:0]        r_ether_type, n_ether_type;
    logic [7:0]         r_version_ihl, n_version_ihl;
    logic [15:0]        r_total_length, n_total_length;
    logic [7:0]         r_proto_byte, n_proto_byte;
    logic [31:0]        r_header_sum, n_header_sum;
    logic [15:0]        r_udp_length, n_udp_length;
    logic               r_udp_check_nonzero, n_udp_check_nonzero;
    logic [31:0]        r_udp_sum, n_udp_sum;
    logic [31:0]        r_udp_ports, n_udp_ports;

    logic               accept;
    logic [7:0]         b;
    logic [COUNT_W-1:0] idx;
    logic [COUNT_W-1:0] kpos;
    logic [COUNT_W-1:0] hs_ext;
    logic [5:0]         hs;
    logic [15:0]        w;
    logic [15:0]        add_a;
    logic [15:0]        add_b;
    logic [16:0]        add_sum;

    assign i_in.ready = !i_q_full;
    assign accept = i_in.valid && i_in.ready;
    assign b = i_in.data_byte;
    assign o_push = accept && i_in.frame_end;

    always_comb begin
        n_byte_count = r_byte_count;
        n_ether_type = r_ether_type;
        n_version_ihl = r_version_ihl;
        n_total_length = r_total_length;
        n_proto_byte = r_proto_byte;
        n_header_sum = r_header_sum;
        n_udp_length = r_udp_length;
        n_udp_check_nonzero = r_udp_check_nonzero;
        n_udp_sum = r_udp_sum;
        n_udp_ports = r_udp_ports;
        idx = r_byte_count - ETH_HDR;
        hs = '0;
        hs_ext = '0;
        kpos = '0;
        w = weigh(idx[0], b);
        add_a = '0;
        add_b = '0;
        add_sum = '0;

        if (r_byte_count == ETHERTYPE_HI_POS) begin
            n_ether_type[15:8] = b;
        end
        if (r_byte_count == ETHERTYPE_LO_POS) begin
            n_ether_type[7:0] = b;
        end

        if (r_byte_count >= ETH_HDR) begin
            if (idx == 17'd0) begin
                n_version_ihl = b;
            end
            hs = {n_version_ihl[3:0], 2'b00};
            hs_ext = {{(COUNT_W-6){1'b0}}, hs};
            if (idx == 17'd2) begin
                n_total_length[15:8] = b;
            end
            if (idx == 17'd3) begin
                n_total_length[7:0] = b;
            end
            if (idx == 17'd9) begin
                n_proto_byte = b;
            end
            if (idx >= 17'd12 && idx <= 17'd19) begin
                add_a = w;
            end
            if (idx < hs_ext) begin
                n_header_sum = r_header_sum + {16'h0000, w};
            end else begin
                kpos = idx - hs_ext;
                case (kpos)
                    17'd0: n_udp_ports[31:24] = b;
                    17'd1: n_udp_ports[23:16] = b;
                    17'd2: n_udp_ports[15:8] = b;
                    17'd3: n_udp_ports[7:0] = b;
                    17'd4: n_udp_length[15:8] = b;
                    17'd5: n_udp_length[7:0] = b;
                    default: begin
                        if ((kpos == 17'd6 || kpos == 17'd7) && b != 8'h00) begin
                            n_udp_check_nonzero = 1'b1;
                        end
                        if (kpos < {1'b0, r_udp_length}) begin
                            add_b = w;
                        end
                    end
                endcase
            end
            add_sum = {1'b0, add_a} + {1'b0, add_b};
            n_udp_sum = r_udp_sum + {15'h0000, add_sum};
        end

        if (r_byte_count < COUNT_MAX) begin
            n_byte_count = r_byte_count + 17'd1;
        end

        o_rec.byte_pos = r_byte_count;
        o_rec.ether_type = n_ether_type;
        o_rec.version_ihl = n_version_ihl;
        o_rec.total_length = n_total_length;
        o_rec.proto_byte = n_proto_byte;
        o_rec.header_sum = n_header_sum;
        o_rec.udp_length = n_udp_length;
        o_rec.udp_check_nonzero = n_udp_check_nonzero;
        o_rec.udp_sum = n_udp_sum;
        o_rec.udp_ports = n_udp_ports;

        if (i_in.frame_end) begin
            n_byte_count = '0;
            n_ether_type = '0;
            n_version_ihl = '0;
            n_total_length = '0;
            n_proto_byte = '0;
            n_header_sum = '0;
            n_udp_length = '0;
            n_udp_check_nonzero = 1'b0;
            n_udp_sum = '0;
            n_udp_ports = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_ether_type <= '0;
            r_version_ihl <= '0;
            r_total_length <= '0;
            r_proto_byte <= '0;
            r_header_sum <= '0;
            r_udp_length <= '0;
            r_udp_check_nonzero <= 1'b0;
            r_udp_sum <= '0;
            r_udp_ports <= '0;
        end else if (accept) begin
            r_byte_count <= n_byte_count;
            r_ether_type <= n_ether_type;
            r_version_ihl <= n_version_ihl;
            r_total_length <= n_total_length;
            r_proto_byte <= n_proto_byte;
            r_header_sum <= n_header_sum;
            r_udp_length <= n_udp_length;
            r_udp_check_nonzero <= n_udp_check_nonzero;
            r_udp_sum <= n_udp_sum;
            r_udp_ports <= n_udp_ports;
        end
    end

endmodule

// ===== hw/rtl/iufc_queue.sv =====
// Short record queue between the byte front end and the verdict pipeline.
module iufc_queue
    import iufc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_rec i_rec,
    input  logic       i_pop,
    output logic       o_valid,
    output logic       o_full,
    output t_frame_rec o_rec
);

    t_frame_rec        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_valid = (r_count != '0);
    assign o_full = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_rec = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/iufc_back.sv =====
// Verdict pipeline: length tests, checksum folding and the result register.
module iufc_back
    import iufc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_frame_rec  i_q_rec,
    output logic        o_pop,
    iufc_out_if.source  o_out
);

    logic        adv;

    logic [17:0] len;
    logic [17:0] size;
    logic [5:0]  hs;
    logic [3:0]  pre_status;
    logic [18:0] extra;
    logic [31:0] s_part;
    logic [16:0] hfold1;

    logic        r_s1_valid;
    logic [3:0]  r_s1_pre_status;
    logic        r_s1_pkt_trunc;
    logic [16:0] r_s1_hfold1;
    logic [31:0] r_s1_s_part;
    logic [18:0] r_s1_extra;
    logic        r_s1_udp_runt;
    logic        r_s1_udp_long;
    logic        r_s1_nonzero;
    logic [7:0]  r_s1_proto;
    logic [5:0]  r_s1_hs;

    logic [16:0] hfold2;
    logic [3:0]  ip_status;

    logic        r_s2_valid;
    logic [3:0]  r_s2_ip_status;
    logic [31:0] r_s2_sum;
    logic        r_s2_udp_runt;
    logic        r_s2_udp_long;
    logic        r_s2_nonzero;
    logic [7:0]  r_s2_proto;
    logic [5:0]  r_s2_hs;

    logic [16:0] ufold1;
    logic [16:0] ufold2;
    logic [2:0]  udp_status;

    logic        r_out_valid;
    logic [3:0]  r_out_ip_status;
    logic [2:0]  r_out_udp_status;
    logic [7:0]  r_out_ip_protocol;
    logic [5:0]  r_out_header_bytes;

    assign adv = !r_out_valid || o_out.ready;
    assign o_pop = adv && i_q_valid;

    always_comb begin
        len = {1'b0, i_q_rec.byte_pos} + 18'd1;
        size = len - {1'b0, ETH_HDR};
        hs = {i_q_rec.version_ihl[3:0], 2'b00};
        if (len < {1'b0, ETH_HDR}) begin
            pre_status = IP_ETH_RUNT;
        end else if (i_q_rec.ether_type < ETHERTYPE_MIN) begin
            pre_status = IP_NOT_ETH2;
        end else if (i_q_rec.ether_type != ETHERTYPE_IPV4) begin
            pre_status = IP_NOT_IPV4;
        end else if (size < {12'h000, IP_MIN_HDR}) begin
            pre_status = IP_RUNT;
        end else if (i_q_rec.version_ihl[7:4] != IP_VERSION_4) begin
            pre_status = IP_BAD_VERSION;
        end else if (hs < IP_MIN_HDR) begin
            pre_status = IP_BAD_IHL;
        end else if (size < {12'h000, hs}) begin
            pre_status = IP_HDR_TRUNC;
        end else begin
            pre_status = IP_OK;
        end

        extra = '0;
        if (i_q_rec.udp_length > 16'd0) begin
            extra = extra + {3'b000, weigh(1'b0, i_q_rec.udp_ports[31:24])};
        end
        if (i_q_rec.udp_length > 16'd1) begin
            extra = extra + {3'b000, weigh(1'b1, i_q_rec.udp_ports[23:16])};
        end
        if (i_q_rec.udp_length > 16'd2) begin
            extra = extra + {3'b000, weigh(1'b0, i_q_rec.udp_ports[15:8])};
        end
        if (i_q_rec.udp_length > 16'd3) begin
            extra = extra + {3'b000, weigh(1'b1, i_q_rec.udp_ports[7:0])};
        end
        if (i_q_rec.udp_length > 16'd4) begin
            extra = extra + {3'b000, weigh(1'b0, i_q_rec.udp_length[15:8])};
        end
        if (i_q_rec.udp_length > 16'd5) begin
            extra = extra + {3'b000, weigh(1'b1, i_q_rec.udp_length[7:0])};
        end

        s_part = i_q_rec.udp_sum + {16'h0000, PROTO_UDP} + {16'h0000, i_q_rec.udp_length};
        hfold1 = {1'b0, i_q_rec.header_sum[31:16]} + {1'b0, i_q_rec.header_sum[15:0]};
    end

    always_comb begin
        hfold2 = {16'h0000, r_s1_hfold1[16]} + {1'b0, r_s1_hfold1[15:0]};
        if (r_s1_pre_status != IP_OK) begin
            ip_status = r_s1_pre_status;
        end else if (hfold2 != {1'b0, SUM_ALL_ONES}) begin
            ip_status = IP_HDR_CHECKSUM;
        end else if (r_s1_pkt_trunc) begin
            ip_status = IP_PKT_TRUNC;
        end else begin
            ip_status = IP_OK;
        end
    end

    always_comb begin
        ufold1 = {1'b0, r_s2_sum[31:16]} + {1'b0, r_s2_sum[15:0]};
        ufold2 = {16'h0000, ufold1[16]} + {1'b0, ufold1[15:0]};
        if (r_s2_ip_status != IP_OK) begin
            udp_status = UDP_SKIPPED;
        end else if (r_s2_udp_runt) begin
            udp_status = UDP_RUNT;
        end else if (r_s2_udp_long) begin
            udp_status = UDP_TOO_LONG;
        end else if (!r_s2_nonzero) begin
            udp_status = UDP_SKIPPED;
        end else if (ufold2 == 17'd0 || ufold2 == {1'b0, SUM_ALL_ONES}) begin
            udp_status = UDP_OK;
        end else begin
            udp_status = UDP_BAD_CHECKSUM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_pre_status <= pre_status;
            r_s1_pkt_trunc <= size < {2'b00, i_q_rec.total_length};
            r_s1_hfold1 <= hfold1;
            r_s1_s_part <= s_part;
            r_s1_extra <= extra;
            r_s1_udp_runt <= ({11'h000, hs} + {11'h000, UDP_HDR})
                             > {1'b0, i_q_rec.total_length};
            r_s1_udp_long <= ({11'h000, hs} + {1'b0, i_q_rec.udp_length})
                             > {1'b0, i_q_rec.total_length};
            r_s1_nonzero <= i_q_rec.udp_check_nonzero;
            r_s1_proto <= i_q_rec.proto_byte;
            r_s1_hs <= hs;

            r_s2_ip_status <= ip_status;
            r_s2_sum <= r_s1_s_part + {13'h0000, r_s1_extra};
            r_s2_udp_runt <= r_s1_udp_runt;
            r_s2_udp_long <= r_s1_udp_long;
            r_s2_nonzero <= r_s1_nonzero;
            r_s2_proto <= r_s1_proto;
            r_s2_hs <= r_s1_hs;

            r_out_ip_status <= r_s2_ip_status;
            r_out_udp_status <= udp_status;
            r_out_ip_protocol <= (r_s2_ip_status == IP_OK) ? r_s2_proto : 8'h00;
            r_out_header_bytes <= (r_s2_ip_status == IP_OK || r_s2_ip_status >= IP_BAD_IHL)
                                  ? r_s2_hs : 6'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_q_valid;
            r_s2_valid <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.ip_status = r_out_ip_status;
    assign o_out.udp_status = r_out_udp_status;
    assign o_out.ip_protocol = r_out_ip_protocol;
    assign o_out.header_bytes = r_out_header_bytes;

endmodule

// ===== hw/rtl/ipv4_udp_frame_checker_unit.sv =====
// Top level of the IPv4/UDP frame checker: front end, record queue and verdict pipeline.
// One frame byte is accepted every cycle while the record queue has room.
// A verdict passes through the record queue, stages s1 and s2 and the result register.
// Frames as short as one byte can follow each other at one per cycle while results are taken.
// The verdict pipeline stalls as a whole while a result waits on the output.
// Synchronous active-low reset empties the queue and pipeline and clears all captured fields.
module ipv4_udp_frame_checker_unit
    import iufc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    iufc_in_if.sink     i_in,
    iufc_out_if.source  o_out
);

    logic       push;
    logic       pop;
    logic       q_valid;
    logic       q_full;
    t_frame_rec front_rec;
    t_frame_rec q_rec;

    iufc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_rec    (front_rec)
    );

    iufc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_rec   (q_rec)
    );

    iufc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_rec   (q_rec),
        .o_pop     (pop),
        .o_out     (o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("frame record pushed into a full queue");

    a_pop_only_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.ip_status <= IP_PKT_TRUNC && o_out.udp_status <= UDP_SKIPPED))
        else $error("result status out of range");

    a_udp_skipped_on_ip_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ip_status != IP_OK)
        |-> (o_out.udp_status == UDP_SKIPPED && o_out.ip_protocol == 8'h00))
        else $error("UDP verdict or protocol given for an invalid IP packet");

endmodule
